// File: rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared widths, constants and types of the barometer compensation block.
// ----------------------------------------------------------------------------
package bpc_pkg;

	localparam int RAW_W     = 24;
	localparam int FRAC_W    = 24;
	localparam int OUT_W     = 32;
	localparam int CFG_W     = 24;
	localparam int REG_IDX_W = 3;

	// x / 31 by reciprocal: floor(x * M / 2^SH), exact over the ranges used here
	localparam int          DIV1_SH = 29;
	localparam logic [24:0] DIV1_M  = 25'd17318417;
	localparam int          DIV2_SH = 21;
	localparam logic [16:0] DIV2_M  = 17'd67651;

	typedef logic [RAW_W-1:0]        raw_t;
	typedef logic signed [OUT_W-1:0] out_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_TEMP_COEFS,
		REG_C00,
		REG_C10,
		REG_C01,
		REG_C11,
		REG_C20,
		REG_C21,
		REG_C30
	} reg_idx_t;

endpackage

// File: rtl/bpc_raw_if.sv
// ----------------------------------------------------------------------------
// bpc_raw_if
// Raw pressure and temperature sample channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bpc_raw_if import bpc_pkg::*; ();

	logic valid;
	logic ready;
	raw_t raw_pressure;
	raw_t raw_temperature;

	modport source (output valid, output raw_pressure, output raw_temperature, input ready);
	modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);

endinterface

// File: rtl/bpc_comp_if.sv
// ----------------------------------------------------------------------------
// bpc_comp_if
// Compensated pressure and temperature result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bpc_comp_if import bpc_pkg::*; ();

	logic valid;
	logic ready;
	out_t pressure_q6;
	out_t temperature_q8;

	modport source (output valid, output pressure_q6, output temperature_q8, input ready);
	modport sink   (input valid, input pressure_q6, input temperature_q8, output ready);

endinterface

// File: rtl/baro_pressure_temp_compensation.sv
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation: polynomial pressure/temperature compensation
// An accepted sample passes through the stage registers s1 to s11; s11 is the output register.
// Throughput: one sample per cycle while the output is not stalled; every stage has its own valid
// bit, so a stalled output only blocks input once all 11 stages are full.
// Reset clears the stage valid bits and the coefficient registers to zero.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation import bpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata,
	bpc_raw_if.sink              raw,
	bpc_comp_if.source           comp
);

	localparam int NS   = 11;
	localparam int QW   = 19;
	localparam int TQW  = 11;
	localparam int PW   = 31;
	localparam int PPW  = 2 * PW;
	localparam int AW   = 46;
	localparam int AHW  = AW - FRAC_W;
	localparam int TPW  = 36;
	localparam int BW   = 51;
	localparam int BHW  = BW - FRAC_W;
	localparam int TCW  = 56;
	localparam int PAW  = 57;
	localparam int PSW  = 58;
	localparam int TSW  = 42;
	localparam int T_SH = FRAC_W - 8;
	localparam int P_SH = FRAC_W - 6;
	localparam int RW   = PSW - P_SH;
	localparam logic [FRAC_W-1:0] RND_HALF = {1'b1, {(FRAC_W-1){1'b0}}};

	// coefficient registers
	logic [CFG_W-1:0]  temp_coefs_q;
	logic signed [19:0] c00_q, c10_q;
	logic signed [15:0] c01_q, c11_q, c20_q, c21_q, c30_q;
	logic signed [11:0] c0, c1;

	assign c0 = $signed(temp_coefs_q[23:12]);
	assign c1 = $signed(temp_coefs_q[11:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coefs_q <= '0;
			c00_q <= '0;
			c10_q <= '0;
			c01_q <= '0;
			c11_q <= '0;
			c20_q <= '0;
			c21_q <= '0;
			c30_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_TEMP_COEFS: temp_coefs_q <= cfg_wdata;
				REG_C00: c00_q <= cfg_wdata[19:0];
				REG_C10: c10_q <= cfg_wdata[19:0];
				REG_C01: c01_q <= cfg_wdata[15:0];
				REG_C11: c11_q <= cfg_wdata[15:0];
				REG_C20: c20_q <= cfg_wdata[15:0];
				REG_C21: c21_q <= cfg_wdata[15:0];
				REG_C30: c30_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// stage valids and per-stage enables
	logic [NS:1] vld_q;
	logic [NS:1] en;

	always_comb begin
		en[NS] = !vld_q[NS] || comp.ready;
		for (int k = NS - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) vld_q[1] <= raw.valid;
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign raw.ready = en[1];

	// scaling lanes: lane 0 pressure, lane 1 temperature
	// q = round(|raw| * 2048 / 31) = 2048 * (x / 31) + floor((rem * 2048 + 15) / 31)
	logic [RAW_W-1:0]    raw_in   [2];
	logic                neg_s1   [2];
	logic                neg_s2   [2];
	logic [RAW_W-1:0]    mag_s1   [2];
	logic [RAW_W-1:0]    mag_s2   [2];
	logic [QW-1:0]       quo_s2   [2];
	logic [RAW_W-1:0]    rem_full [2];
	logic signed [PW-1:0] sc_s3   [2];

	assign raw_in[0] = raw.raw_pressure;
	assign raw_in[1] = raw.raw_temperature;

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic [RAW_W+24:0]   qprod;
		logic [15:0]         yv;
		logic [32:0]         tprod;
		logic [TQW-1:0]      tq;
		logic [QW+TQW-1:0]   qv;

		always_comb begin
			qprod = mag_s1[l] * DIV1_M;
			rem_full[l] = mag_s2[l] - ((RAW_W'(quo_s2[l]) << 5) - RAW_W'(quo_s2[l]));
			yv = {rem_full[l][4:0], 11'd15};
			tprod = yv * DIV2_M;
			tq = tprod[DIV2_SH+TQW-1:DIV2_SH];
			qv = {quo_s2[l], tq};
		end

		always_ff @(posedge clk) begin
			if (en[1]) begin
				neg_s1[l] <= raw_in[l][RAW_W-1];
				mag_s1[l] <= raw_in[l][RAW_W-1] ? -raw_in[l] : raw_in[l];
			end
			if (en[2]) begin
				neg_s2[l] <= neg_s1[l];
				mag_s2[l] <= mag_s1[l];
				quo_s2[l] <= qprod[DIV1_SH+QW-1:DIV1_SH];
			end
			if (en[3]) begin
				sc_s3[l] <= neg_s2[l] ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
			end
		end
	end

	// polynomial pipeline
	logic signed [PW+15:0]  pc30, pc21, tc01;
	logic signed [PW+11:0]  tc1;
	logic signed [PPW-1:0]  ptx;
	logic signed [AW-1:0]   a_d, c_d;
	logic signed [TSW-1:0]  tsum_d;

	logic signed [PW-1:0]   p_s4, p_s5, p_s6, p_s7;
	logic signed [AW-1:0]   a_s4, c_s4, c_s5;
	logic signed [PPW-1:0]  tpx_s4;
	logic signed [PW+15:0]  tc01_s4, tc01_s5, tc01_s6;
	logic signed [TSW-1:0]  tsum_s4;

	logic signed [PW+FRAC_W:0]    pal, pal_s5;
	logic signed [PW+AHW-1:0]     pah, pah_s5;
	logic                         pa_neg_s5;
	logic [PPW-1:0]               tpr;
	logic [TSW-1:0]               tr;
	logic signed [TPW-1:0]        tp_s5;
	logic signed [OUT_W-1:0]      temp_d;
	logic signed [OUT_W-1:0]      temp_s5, temp_s6, temp_s7, temp_s8, temp_s9, temp_s10;
	logic signed [OUT_W-1:0]      temp_s11;

	logic                         pa_cy;
	logic signed [BW-1:0]         r1_d, r1_s6;
	logic signed [TPW+FRAC_W:0]   tcl, tcl_s6;
	logic signed [TPW+AHW-1:0]    tch, tch_s6;
	logic                         tc_neg_s6;

	logic                         tc_cy;
	logic signed [BW-1:0]         b_d, b_s7;
	logic signed [TCW-1:0]        tc_d, tc_s7;
	logic signed [PSW-1:0]        ps_d, ps_s7, ps_s8, ps_s9;

	logic signed [PW+FRAC_W:0]    pbl, pbl_s8;
	logic signed [PW+BHW-1:0]     pbh, pbh_s8;
	logic                         pb_neg_s8;

	logic                         pb_cy;
	logic signed [PAW-1:0]        pa_d, pa_s9;
	logic signed [PSW-1:0]        psum_s10;

	logic [PSW-1:0]               pr;
	logic [RW-1:0]                prs;
	logic [RW-OUT_W:0]            prs_hi;
	logic signed [OUT_W-1:0]      pres_d, pres_s11;

	always_comb begin
		// stage 4: first-order terms
		pc30 = sc_s3[0] * c30_q;
		pc21 = sc_s3[0] * c21_q;
		tc01 = sc_s3[1] * c01_q;
		tc1  = sc_s3[1] * c1;
		ptx  = sc_s3[1] * sc_s3[0];
		a_d  = (AW'(c20_q) <<< FRAC_W) + AW'(pc30);
		c_d  = (AW'(c11_q) <<< FRAC_W) + AW'(pc21);
		tsum_d = (TSW'(c0) <<< (FRAC_W - 1)) + TSW'(tc1);

		// stage 5: split P*A, round T*P, finish temperature
		pal = p_s4 * $signed({1'b0, a_s4[FRAC_W-1:0]});
		pah = p_s4 * $signed(a_s4[AW-1:FRAC_W]);
		tpr = tpx_s4 + (PPW'(1) << (FRAC_W - 1)) - PPW'(tpx_s4[PPW-1]);
		// temperature result is below 2^25 in magnitude, no saturation needed
		tr = tsum_s4 + (TSW'(1) << (T_SH - 1)) - TSW'(tsum_s4[TSW-1]);
		temp_d = OUT_W'($signed(tr[TSW-1:T_SH]));

		// stage 6: recombine P*A with round half away, split TP*C
		pa_cy = pa_neg_s5 ? (pal_s5[FRAC_W-1:0] > RND_HALF) : (pal_s5[FRAC_W-1:0] >= RND_HALF);
		r1_d = BW'(pah_s5) + BW'(pal_s5 >>> FRAC_W) + BW'(pa_cy);
		tcl = tp_s5 * $signed({1'b0, c_s5[FRAC_W-1:0]});
		tch = tp_s5 * $signed(c_s5[AW-1:FRAC_W]);

		// stage 7
		b_d = (BW'(c10_q) <<< FRAC_W) + r1_s6;
		tc_cy = tc_neg_s6 ? (tcl_s6[FRAC_W-1:0] > RND_HALF) : (tcl_s6[FRAC_W-1:0] >= RND_HALF);
		tc_d = TCW'(tch_s6) + TCW'(tcl_s6 >>> FRAC_W) + TCW'(tc_cy);
		ps_d = (PSW'(c00_q) <<< FRAC_W) + PSW'(tc01_s6);

		// stage 8: split P*B
		pbl = p_s7 * $signed({1'b0, b_s7[FRAC_W-1:0]});
		pbh = p_s7 * $signed(b_s7[BW-1:FRAC_W]);

		// stage 9
		pb_cy = pb_neg_s8 ? (pbl_s8[FRAC_W-1:0] > RND_HALF) : (pbl_s8[FRAC_W-1:0] >= RND_HALF);
		pa_d = PAW'(pbh_s8) + PAW'(pbl_s8 >>> FRAC_W) + PAW'(pb_cy);

		// stage 11: Q24 -> Q6 and saturate
		pr = psum_s10 + (PSW'(1) << (P_SH - 1)) - PSW'(psum_s10[PSW-1]);
		prs = pr[PSW-1:P_SH];
		prs_hi = prs[RW-1:OUT_W-1];
		if (prs_hi == '0 || prs_hi == '1) begin
			pres_d = $signed(prs[OUT_W-1:0]);
		end else if (prs[RW-1]) begin
			pres_d = $signed({1'b1, {(OUT_W-1){1'b0}}});
		end else begin
			pres_d = $signed({1'b0, {(OUT_W-1){1'b1}}});
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			p_s4    <= sc_s3[0];
			a_s4    <= a_d;
			c_s4    <= c_d;
			tpx_s4  <= ptx;
			tc01_s4 <= tc01;
			tsum_s4 <= tsum_d;
		end
		if (en[5]) begin
			p_s5      <= p_s4;
			c_s5      <= c_s4;
			pal_s5    <= pal;
			pah_s5    <= pah;
			pa_neg_s5 <= p_s4[PW-1] ^ a_s4[AW-1];
			tp_s5     <= $signed(tpr[FRAC_W+TPW-1:FRAC_W]);
			tc01_s5   <= tc01_s4;
			temp_s5   <= temp_d;
		end
		if (en[6]) begin
			p_s6      <= p_s5;
			r1_s6     <= r1_d;
			tcl_s6    <= tcl;
			tch_s6    <= tch;
			tc_neg_s6 <= tp_s5[TPW-1] ^ c_s5[AW-1];
			tc01_s6   <= tc01_s5;
			temp_s6   <= temp_s5;
		end
		if (en[7]) begin
			p_s7    <= p_s6;
			b_s7    <= b_d;
			tc_s7   <= tc_d;
			ps_s7   <= ps_d;
			temp_s7 <= temp_s6;
		end
		if (en[8]) begin
			pbl_s8    <= pbl;
			pbh_s8    <= pbh;
			pb_neg_s8 <= p_s7[PW-1] ^ b_s7[BW-1];
			ps_s8     <= ps_s7 + PSW'(tc_s7);
			temp_s8   <= temp_s7;
		end
		if (en[9]) begin
			pa_s9   <= pa_d;
			ps_s9   <= ps_s8;
			temp_s9 <= temp_s8;
		end
		if (en[10]) begin
			psum_s10 <= ps_s9 + PSW'(pa_s9);
			temp_s10 <= temp_s9;
		end
		if (en[11]) begin
			pres_s11 <= pres_d;
			temp_s11 <= temp_s10;
		end
	end

	assign comp.valid          = vld_q[NS];
	assign comp.pressure_q6    = pres_s11;
	assign comp.temperature_q8 = temp_s11;

	// an empty output register means the whole pipe can move
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!comp.valid |-> raw.ready)
		else $error("input blocked while output register is empty");

	// input only stalls when a result is held back by the sink
	a_stall_from_sink: assert property (@(posedge clk) disable iff (!arst_n)
		!raw.ready |-> (comp.valid && !comp.ready))
		else $error("input stalled without output backpressure");

	// reciprocal divide by 31 must leave a remainder below 31
	a_div31_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[2] |-> (rem_full[0] < RAW_W'(31) && rem_full[1] < RAW_W'(31)))
		else $error("divide by 31 remainder out of range");

endmodule

// File: sim/bpc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bpc_checker
// Watches the coefficient port and both sample channels of the barometer
// compensation block, computes the compensated reading of every accepted raw
// sample and compares it, in order, with what the block delivers.
// ----------------------------------------------------------------------------
module bpc_checker import bpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata,
	bpc_raw_if                   raw,
	bpc_comp_if                  comp,
	output int                   fails,
	output int                   pending,
	output int                   checked
);

	localparam logic [63:0]  OSR_DIV = 64'd253952;
	localparam logic [127:0] MAG_CAP = 128'd1 << 62;

	typedef struct packed {
		out_t pressure_q6;
		out_t temperature_q8;
	} reading_t;

	// local copy of the coefficient registers
	logic [CFG_W-1:0]   temp_coefs;
	logic signed [19:0] c00, c10;
	logic signed [15:0] c01, c11, c20, c21, c30;

	reading_t expected_readings[$];
	int       n_fail    = 0;
	int       n_checked = 0;

	// round(a*b / 2^sh), ties away from zero, magnitude capped at 2^62
	function automatic longint round_mul(input longint a, input longint b, input int sh);
		logic [63:0]  ma, mb;
		logic [127:0] q;
		logic         neg;
		neg = (a < 0) != (b < 0);
		ma  = (a < 0) ? 64'(-a) : 64'(a);
		mb  = (b < 0) ? 64'(-b) : 64'(b);
		q   = ((128'(ma) * 128'(mb)) + (128'd1 << (sh - 1))) >> sh;
		if (q > MAG_CAP)
			q = MAG_CAP;
		return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	// raw reading over the oversampling factor, Q24, rounded to nearest
	function automatic longint scale_q24(input raw_t r);
		longint      s;
		logic [63:0] m, q;
		s = longint'($signed(r));
		m = ((s < 0) ? 64'(-s) : 64'(s)) << FRAC_W;
		q = (2 * m + OSR_DIV) / (2 * OSR_DIV);
		return (s < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic out_t clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return out_t'(v);
	endfunction

	function automatic reading_t compensate_reading(input raw_t rp, input raw_t rt);
		longint   one, p, t, a, b, pa, c, tp, tc, psum, tsum;
		reading_t res;
		one  = longint'(1) << FRAC_W;
		p    = scale_q24(rp);
		t    = scale_q24(rt);
		// pressure polynomial in horner form
		a    = longint'(c20) * one + p * longint'(c30);
		b    = longint'(c10) * one + round_mul(p, a, FRAC_W);
		pa   = round_mul(p, b, FRAC_W);
		c    = longint'(c11) * one + p * longint'(c21);
		tp   = round_mul(t, p, FRAC_W);
		tc   = round_mul(tp, c, FRAC_W);
		psum = longint'(c00) * one + pa + t * longint'(c01) + tc;
		tsum = longint'($signed(temp_coefs[23:12])) * (one / 2)
			+ t * longint'($signed(temp_coefs[11:0]));
		res.pressure_q6    = clamp32(round_mul(psum, 1, FRAC_W - 6));
		res.temperature_q8 = clamp32(round_mul(tsum, 1, FRAC_W - 8));
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			temp_coefs <= '0;
			c00        <= '0;
			c10        <= '0;
			c01        <= '0;
			c11        <= '0;
			c20        <= '0;
			c21        <= '0;
			c30        <= '0;
			fails      <= 0;
			pending    <= 0;
			checked    <= 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_idx))
					REG_TEMP_COEFS: temp_coefs <= cfg_wdata;
					REG_C00:        c00 <= cfg_wdata[19:0];
					REG_C10:        c10 <= cfg_wdata[19:0];
					REG_C01:        c01 <= cfg_wdata[15:0];
					REG_C11:        c11 <= cfg_wdata[15:0];
					REG_C20:        c20 <= cfg_wdata[15:0];
					REG_C21:        c21 <= cfg_wdata[15:0];
					REG_C30:        c30 <= cfg_wdata[15:0];
					default: ;
				endcase
			end
			// results first: a sample accepted on this edge cannot come out on it
			if (comp.valid && comp.ready) begin
				if (expected_readings.size() == 0) begin
					$display({"%0t: result with nothing outstanding, ",
						"pressure_q6 %0d, temperature_q8 %0d"},
						$time, comp.pressure_q6, comp.temperature_q8);
					n_fail++;
				end else begin
					want = expected_readings.pop_front();
					if (comp.pressure_q6 !== want.pressure_q6) begin
						$display("%0t: pressure_q6 mismatch, expected %0d, actual %0d",
							$time, want.pressure_q6, comp.pressure_q6);
						n_fail++;
					end
					if (comp.temperature_q8 !== want.temperature_q8) begin
						$display("%0t: temperature_q8 mismatch, expected %0d, actual %0d",
							$time, want.temperature_q8, comp.temperature_q8);
						n_fail++;
					end
					n_checked++;
				end
			end
			if (raw.valid && raw.ready)
				expected_readings.push_back(
					compensate_reading(raw.raw_pressure, raw.raw_temperature));
			fails   <= n_fail;
			pending <= expected_readings.size();
			checked <= n_checked;
		end
	end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the barometer compensation block with corner and random raw samples
// under several coefficient settings and idle patterns; the checker beside
// the block predicts and compares every compensated reading.
// ----------------------------------------------------------------------------
module tb;
	import bpc_pkg::*;

	typedef enum {COEF_RANDOM, COEF_MAX, COEF_MIN, COEF_MIXED} coef_mode_t;

	typedef struct {
		logic [CFG_W-1:0] temp_coefs;
		logic [CFG_W-1:0] c00, c10, c01, c11, c20, c21, c30;
	} coef_set_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;

	int gap_pct    = 0;
	int stall_pct  = 0;
	int n_samples  = 0;
	int n_settings = 0;
	int fails, pending, checked;

	raw_t       corner_p[6]     = '{24'h000000, 24'h7FFFFF, 24'h800000,
		24'hFFFFFF, 24'h7FFFFF, 24'h800000};
	raw_t       corner_t[6]     = '{24'h000000, 24'h7FFFFF, 24'h800000,
		24'h000001, 24'h800000, 24'h7FFFFF};
	coef_mode_t corner_modes[3] = '{COEF_MAX, COEF_MIN, COEF_MIXED};

	bpc_raw_if  raw ();
	bpc_comp_if comp ();

	baro_pressure_temp_compensation u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.raw       (raw),
		.comp      (comp)
	);

	bpc_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.raw       (raw),
		.comp      (comp),
		.fails     (fails),
		.pending   (pending),
		.checked   (checked)
	);

	always #10 clk = ~clk;

	// signed field of width w, upper bits of the word filled with junk
	function automatic logic [CFG_W-1:0] coef_field(input int w, input coef_mode_t mode);
		logic [CFG_W-1:0] mask, v;
		coef_mode_t       m;
		mask = (24'd1 << w) - 24'd1;
		m    = mode;
		if (m == COEF_MIXED || (m == COEF_RANDOM && $urandom_range(5) == 0))
			m = $urandom_range(1) ? COEF_MAX : COEF_MIN;
		case (m)
			COEF_MAX: v = mask >> 1;
			COEF_MIN: v = ~(mask >> 1);
			default:  v = CFG_W'($urandom);
		endcase
		return (CFG_W'($urandom) & ~mask) | (v & mask);
	endfunction

	function automatic coef_set_t make_coefs(input coef_mode_t mode);
		coef_set_t s;
		logic [CFG_W-1:0] hi, lo;
		hi           = coef_field(12, mode);
		lo           = coef_field(12, mode);
		s.temp_coefs = {hi[11:0], lo[11:0]};
		s.c00        = coef_field(20, mode);
		s.c10        = coef_field(20, mode);
		s.c01        = coef_field(16, mode);
		s.c11        = coef_field(16, mode);
		s.c20        = coef_field(16, mode);
		s.c21        = coef_field(16, mode);
		s.c30        = coef_field(16, mode);
		return s;
	endfunction

	function automatic raw_t pick_raw();
		case ($urandom_range(9))
			0:       return raw_t'(24'h7FFFFF - $urandom_range(1023));
			1:       return raw_t'(24'h800000 + $urandom_range(1023));
			2:       return raw_t'($urandom_range(2047) - 1024);
			default: return raw_t'($urandom);
		endcase
	endfunction

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	// only once the pipeline has drained
	task automatic load_coefs(input coef_set_t s);
		do @(posedge clk); while (pending != 0);
		write_reg(REG_TEMP_COEFS, s.temp_coefs);
		write_reg(REG_C00, s.c00);
		write_reg(REG_C10, s.c10);
		write_reg(REG_C01, s.c01);
		write_reg(REG_C11, s.c11);
		write_reg(REG_C20, s.c20);
		write_reg(REG_C21, s.c21);
		write_reg(REG_C30, s.c30);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task automatic push_sample(input raw_t p, input raw_t t);
		while ($urandom_range(99) < gap_pct) begin
			raw.valid <= 1'b0;
			@(posedge clk);
		end
		raw.valid           <= 1'b1;
		raw.raw_pressure    <= p;
		raw.raw_temperature <= t;
		do @(posedge clk); while (!raw.ready);
		n_samples++;
	endtask

	// receiver side
	initial begin
		comp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			comp.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		#5000000;
		$display("timeout with %0d results outstanding", pending);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_idx             <= '0;
		cfg_wdata           <= '0;
		raw.valid           <= 1'b0;
		raw.raw_pressure    <= '0;
		raw.raw_temperature <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners with the reset coefficients, then with extreme settings
		push_sample(corner_p[1], corner_t[1]);
		push_sample(corner_p[2], corner_t[2]);
		foreach (corner_modes[m]) begin
			raw.valid <= 1'b0;
			load_coefs(make_coefs(corner_modes[m]));
			foreach (corner_p[i])
				push_sample(corner_p[i], corner_t[i]);
		end

		for (int r = 0; r < 8; r++) begin
			raw.valid <= 1'b0;
			load_coefs(make_coefs(r == 0 ? COEF_MAX : (r == 1 ? COEF_MIN : COEF_RANDOM)));
			case (r % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 75; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 75; end
				default: begin gap_pct = 37; stall_pct = 37; end
			endcase
			repeat (94)
				push_sample(pick_raw(), pick_raw());
		end
		raw.valid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (24) @(posedge clk);

		$display("%0d raw samples over %0d coefficient settings, %0d readings compared",
			n_samples, n_settings, checked);
		$display("idle patterns: none, sender gaps, receiver stalls, both together");
		if (fails == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
